@@ src/qrc_pkg.sv @@
// Shared types and constants of the quadcopter RC packet builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package qrc_pkg;

    localparam int FULL_SCALE_DEF  = 500;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int FRAME_BYTES     = 16;
    localparam int POS_W           = 4;
    localparam int CFG_INDEX_W     = 8;
    localparam int CFG_DATA_W      = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_VIDEO_FREQ_OPTION = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSMITTER_ID    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SESSION_ID        = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIO_CHANNEL     = 8'd3;

    // Register reset values.
    localparam logic [6:0]  RST_VIDEO_FREQ_OPTION = 7'd0;
    localparam logic [31:0] RST_TRANSMITTER_ID    = 32'hdb04_2679;
    localparam logic [31:0] RST_SESSION_ID        = 32'd0;
    localparam logic [7:0]  RST_RADIO_CHANNEL     = 8'd20;

    // Frame contents.
    localparam logic [7:0]  HDR_VIDEO     = 8'h40;
    localparam logic [7:0]  HDR_THROTTLE  = 8'h20;
    localparam logic [7:0]  VIDEO_TRAILER = 8'h82;
    localparam logic [7:0]  DATA_TAIL     = 8'h64;
    localparam logic [7:0]  BIND_B6       = 8'h08;
    localparam logic [7:0]  BIND_B7       = 8'he4;
    localparam logic [7:0]  BIND_B8       = 8'hea;
    localparam logic [7:0]  BIND_B9       = 8'h9e;
    localparam logic [7:0]  BIND_B10      = 8'h50;
    localparam logic [7:0]  FLAGS_STARTUP = 8'h0e;
    localparam logic [7:0]  FLAGS_BASE    = 8'h02;
    localparam logic [7:0]  LED_FLAG_BIT  = 8'h04;
    localparam logic [7:0]  FLIP_FLAG_BIT = 8'h08;
    localparam logic [7:0]  VIDEO_FLAG_BIT = 8'h01;
    localparam logic [12:0] FREQ_BASE     = 13'd5645;
    localparam logic [6:0]  STARTUP_FRAMES = 7'd100;
    localparam logic [6:0]  COUNT_MAX     = 7'd127;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    typedef struct packed {
        logic               mode;
        logic [7:0]         bind_code;
        logic signed [15:0] throttle;
        logic signed [15:0] rudder;
        logic signed [15:0] elevator;
        logic signed [15:0] aileron;
        logic signed [15:0] aux_led;
        logic signed [15:0] aux_flip;
        logic signed [15:0] aux_video;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       frame_byte;
        logic [POS_W-1:0] byte_position;
        logic             last_byte;
    } out_item_t;

    // Frame body, bytes 0 to 14; the checksum is added while serializing.
    typedef logic [FRAME_BYTES-2:0][7:0] frame_body_t;

    // Queue handshake status seen by the serializer.
    typedef struct packed {
        logic valid;
        logic ready;
    } queue_ctl_t;

endpackage

@@ src/quadcopter_rc_packet_builder_unit.sv @@
// Top level of the quadcopter RC packet builder: front end, frame queue and serializer.
// Depends on qrc_pkg, qrc_front, qrc_queue and qrc_serializer.
//
//   Channel  | Ports                                 | Carries
//   ---------+---------------------------------------+--------------------------------
//   request  | s_valid / s_ready / s_data            | one frame request (in_item_t)
//   result   | m_valid / m_ready / m_data            | one frame byte (out_item_t)
//   config   | cfg_valid / cfg_ready / cfg_index,data| register write, always ready
//
// Each request yields sixteen bytes, one per cycle from the serializer while m_ready
// stays high; the front end takes new requests while earlier frames are still being sent.
// A request reaches the first byte through the first scaler stage, loaded on the accepting edge,
// then two more scaler stages, the queue and the output register.
// Reset is synchronous on aresetn low and restores the registers and frame state.
// While m_ready is low the output holds; the front end keeps taking requests
// until its three stages and the queue are full.
`timescale 1ns / 1ps

module quadcopter_rc_packet_builder_unit
    import qrc_pkg::*;
#(
    parameter int FULL_SCALE  = FULL_SCALE_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic        push_valid;
    logic        push_ready;
    frame_body_t push_data;
    queue_ctl_t  head_ctl;
    frame_body_t head_data;
    logic        pop;

    assign cfg_ready = 1'b1;

    qrc_front #(.FULL_SCALE(FULL_SCALE)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    qrc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_ctl_o  (head_ctl),
        .pop        (pop),
        .pop_data   (head_data)
    );

    qrc_serializer u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_ctl  (head_ctl),
        .head_data (head_data),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ src/qrc_stick_scale.sv @@
// Three-stage stick scaler: control*128/FULL_SCALE+128, truncated, clamped to 0..255.
// Uses a reciprocal multiply with one correction step; depends on qrc_pkg.
`timescale 1ns / 1ps

module qrc_stick_scale
    import qrc_pkg::*;
#(
    parameter int FULL_SCALE = FULL_SCALE_DEF
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] stick,
    output logic [7:0]         scaled
);

    localparam int A_W = 23;
    localparam int RECIP_W = 24;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << A_W) / FULL_SCALE);
    localparam logic [A_W-1:0] FS_A = A_W'(FULL_SCALE);
    localparam logic [A_W-1:0] SAT_LIMIT = A_W'(128 * FULL_SCALE);

    logic                     sign1_reg;
    logic [15:0]              mag1_reg;
    logic                     sign2_reg;
    logic                     sat2_reg;
    logic [A_W-1:0]           a2_reg;
    logic [A_W+RECIP_W-1:0]   prod2_reg;
    logic                     sign3_reg;
    logic                     sat3_reg;
    logic [7:0]               q3_reg;

    logic [A_W-1:0] a1;
    logic [6:0]     q0;
    logic [A_W-1:0] rem;

    assign a1  = {mag1_reg, 7'b0};
    assign q0  = prod2_reg[A_W+6:A_W];
    assign rem = a2_reg - A_W'({16'b0, q0} * FS_A);

    always_ff @(posedge aclk) begin
        if (en) begin
            sign1_reg <= stick[15];
            mag1_reg  <= stick[15] ? 16'(-stick) : 16'(stick);
            sign2_reg <= sign1_reg;
            a2_reg    <= a1;
            sat2_reg  <= (a1 >= SAT_LIMIT);
            prod2_reg <= (A_W+RECIP_W)'(a1) * (A_W+RECIP_W)'(RECIP);
            sign3_reg <= sign2_reg;
            sat3_reg  <= sat2_reg;
            q3_reg    <= (rem >= FS_A) ? 8'({1'b0, q0}) + 8'd1 : 8'({1'b0, q0});
        end
    end

    // A quotient of 128 or more saturates either way.
    always_comb begin
        if (sat3_reg) begin
            scaled = sign3_reg ? 8'd0 : 8'd255;
        end else if (sign3_reg) begin
            scaled = 8'd128 - q3_reg;
        end else begin
            scaled = 8'd128 + q3_reg;
        end
    end

endmodule

@@ src/qrc_front.sv @@
// Front end: configuration registers, request intake, frame-count state and frame assembly.
// Instantiates qrc_stick_scale; depends on qrc_pkg.
`timescale 1ns / 1ps

module qrc_front
    import qrc_pkg::*;
#(
    parameter int FULL_SCALE = FULL_SCALE_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   push_valid,
    input  logic                   push_ready,
    output frame_body_t            push_data
);

    typedef struct packed {
        logic        mode;
        logic [7:0]  bind_code;
        logic        video;
        logic [12:0] freq;
        logic [7:0]  flags;
    } ctl_t;

    logic [6:0]  opt_reg;
    logic [31:0] tid_reg;
    logic [31:0] sid_reg;
    logic [7:0]  chan_reg;
    logic [6:0]  count_reg;
    logic [6:0]  count_next;
    logic [12:0] sent_reg;
    logic [12:0] sent_next;

    logic v1_reg, v2_reg, v3_reg;
    ctl_t c1_reg, c2_reg, c3_reg;
    ctl_t c0;

    logic        adv;
    logic        accept;
    logic [12:0] freq_now;
    logic        video_now;
    logic [6:0]  count_mid;
    logic        startup;
    logic [7:0]  thr_b, rud_b, ele_b, ail_b;

    assign adv        = !v3_reg || push_ready;
    assign s_ready    = adv;
    assign accept     = s_valid && adv;
    assign push_valid = v3_reg;

    // Video frames bump the counter before the flags decision sees it.
    always_comb begin
        freq_now  = FREQ_BASE + 13'({opt_reg, 2'b00}) + 13'(opt_reg);
        video_now = (sent_reg != freq_now) || (count_reg == STARTUP_FRAMES);
        count_mid = (video_now && count_reg != COUNT_MAX) ? count_reg + 7'd1 : count_reg;
        startup   = (count_mid < STARTUP_FRAMES);
        count_next = startup ? count_mid + 7'd1 : count_mid;
        sent_next  = video_now ? freq_now : sent_reg;

        c0.mode      = s_data.mode;
        c0.bind_code = s_data.bind_code;
        c0.video     = video_now;
        c0.freq      = freq_now;
        if (startup) begin
            c0.flags = FLAGS_STARTUP;
        end else begin
            c0.flags = FLAGS_BASE
                     | (!s_data.aux_led[15]  ? LED_FLAG_BIT  : 8'h00)
                     | (!s_data.aux_flip[15] ? FLIP_FLAG_BIT : 8'h00)
                     | ((!s_data.aux_video[15] && s_data.aux_video != 16'sd0)
                        ? VIDEO_FLAG_BIT : 8'h00);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opt_reg   <= RST_VIDEO_FREQ_OPTION;
            tid_reg   <= RST_TRANSMITTER_ID;
            sid_reg   <= RST_SESSION_ID;
            chan_reg  <= RST_RADIO_CHANNEL;
            count_reg <= '0;
            sent_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_VIDEO_FREQ_OPTION: opt_reg  <= cfg_data[6:0];
                    REG_TRANSMITTER_ID:    tid_reg  <= cfg_data;
                    REG_SESSION_ID:        sid_reg  <= cfg_data;
                    REG_RADIO_CHANNEL:     chan_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            // Bind requests leave the frame state alone.
            if (accept && !s_data.mode) begin
                count_reg <= count_next;
                sent_reg  <= sent_next;
            end
            if (adv) begin
                v1_reg <= s_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg <= c0;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    qrc_stick_scale #(.FULL_SCALE(FULL_SCALE)) u_thr (
        .aclk(aclk), .en(adv), .stick(s_data.throttle), .scaled(thr_b)
    );
    qrc_stick_scale #(.FULL_SCALE(FULL_SCALE)) u_rud (
        .aclk(aclk), .en(adv), .stick(s_data.rudder), .scaled(rud_b)
    );
    qrc_stick_scale #(.FULL_SCALE(FULL_SCALE)) u_ele (
        .aclk(aclk), .en(adv), .stick(s_data.elevator), .scaled(ele_b)
    );
    qrc_stick_scale #(.FULL_SCALE(FULL_SCALE)) u_ail (
        .aclk(aclk), .en(adv), .stick(s_data.aileron), .scaled(ail_b)
    );

    always_comb begin
        push_data = '0;
        if (c3_reg.mode) begin
            push_data[0]  = c3_reg.bind_code;
            push_data[1]  = chan_reg;
            push_data[2]  = sid_reg[31:24];
            push_data[3]  = sid_reg[23:16];
            push_data[4]  = sid_reg[15:8];
            push_data[5]  = sid_reg[7:0];
            push_data[6]  = BIND_B6;
            push_data[7]  = BIND_B7;
            push_data[8]  = BIND_B8;
            push_data[9]  = BIND_B9;
            push_data[10] = BIND_B10;
        end else begin
            if (c3_reg.video) begin
                push_data[0] = HDR_VIDEO;
                push_data[1] = 8'({3'b000, c3_reg.freq[12:8]});
                push_data[2] = c3_reg.freq[7:0];
                push_data[3] = VIDEO_TRAILER;
            end else begin
                push_data[0] = HDR_THROTTLE;
                push_data[2] = thr_b;
            end
            push_data[4]  = ~rud_b;
            push_data[6]  = ~ele_b;
            push_data[8]  = ail_b;
            push_data[9]  = c3_reg.flags;
            push_data[10] = DATA_TAIL;
        end
        push_data[11] = tid_reg[31:24];
        push_data[12] = tid_reg[23:16];
        push_data[13] = tid_reg[15:8];
        push_data[14] = tid_reg[7:0];
    end

endmodule

@@ src/qrc_queue.sv @@
// Short register queue of assembled frame bodies between front end and serializer.
// Depends on qrc_pkg.
`timescale 1ns / 1ps

module qrc_queue
    import qrc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  frame_body_t push_data,
    output queue_ctl_t  pop_ctl_o,
    input  logic        pop,
    output frame_body_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    frame_body_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready      = (cnt_reg != CNT_FULL);
    assign pop_ctl_o.valid = (cnt_reg != '0);
    assign pop_ctl_o.ready = push_ready;
    assign pop_data        = mem_reg[rd_reg];
    assign do_push         = push_valid && push_ready;
    assign do_pop          = pop && pop_ctl_o.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == PTR_LAST) ? '0 : wr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PTR_LAST) ? '0 : rd_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

@@ src/qrc_serializer.sv @@
// Back end: sends the head frame one byte per cycle unless m_ready stalls it,
// and appends the negated byte sum. Depends on qrc_pkg.
`timescale 1ns / 1ps

module qrc_serializer
    import qrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  queue_ctl_t  head_ctl,
    input  frame_body_t head_data,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic [POS_W-1:0] pos_reg;
    logic [7:0]       sum_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;
    logic             emit;
    logic             at_last;
    logic [7:0]       byte_now;

    assign emit    = head_ctl.valid && (!m_valid_reg || m_ready);
    assign at_last = (pos_reg == LAST_POS);
    assign pop     = emit && at_last;
    assign byte_now = at_last ? 8'(8'd0 - sum_reg) : head_data[pos_reg];
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
                pos_reg     <= pos_reg + POS_W'(1);
                sum_reg     <= at_last ? 8'd0 : sum_reg + byte_now;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg.frame_byte    <= byte_now;
            m_data_reg.byte_position <= pos_reg;
            m_data_reg.last_byte     <= at_last;
        end
    end

endmodule

@@ src/qrc_checker.sv @@
// Port-level checker for the quadcopter RC packet builder, bound to the top level.
// Depends on qrc_pkg.
`timescale 1ns / 1ps

module qrc_checker
    import qrc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    logic [POS_W-1:0] exp_pos_reg;
    logic [3:0]       open_reg;
    logic             s_acc;
    logic             m_acc;
    logic             frame_done;

    assign s_acc      = s_valid && s_ready;
    assign m_acc      = m_valid && m_ready;
    assign frame_done = m_acc && m_data.last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_pos_reg <= '0;
            open_reg    <= '0;
        end else begin
            if (m_acc) begin
                exp_pos_reg <= m_data.byte_position + POS_W'(1);
            end
            if (s_acc && !frame_done) begin
                open_reg <= open_reg + 4'd1;
            end else if (frame_done && !s_acc) begin
                open_reg <= open_reg - 4'd1;
            end
        end
    end

    // A stalled result byte must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Bytes of a frame come in order, none skipped or repeated.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.byte_position == exp_pos_reg)
        else $error("byte position out of sequence");

    // Only the checksum byte closes a frame.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_byte == (m_data.byte_position == LAST_POS)))
        else $error("last flag on wrong position");

    // No byte without a request still in flight.
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> open_reg != 4'd0)
        else $error("result without a pending request");

endmodule

bind quadcopter_rc_packet_builder_unit qrc_checker u_qrc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ dv/tb_quadcopter_rc_packet_builder_unit.sv @@
// Testbench for quadcopter_rc_packet_builder_unit: predicts each 16-byte frame per request
// and checks every emitted byte. Depends on qrc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_quadcopter_rc_packet_builder_unit;
    import qrc_pkg::*;

    localparam int WATCHDOG_LIMIT      = 2000;
    localparam int BACKPRESSURE_AFTER  = 60;
    localparam int BACKPRESSURE_CYCLES = 200;
    localparam int TAIL_CYCLES         = 20;

    // Indexes outside the register map; writes to them must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE      = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_INDEX = 8'hff;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predicted register and frame state.
    logic [6:0]  video_option   = RST_VIDEO_FREQ_OPTION;
    logic [31:0] tx_id          = RST_TRANSMITTER_ID;
    logic [31:0] session        = RST_SESSION_ID;
    logic [7:0]  rf_channel     = RST_RADIO_CHANNEL;
    logic [6:0]  data_frames    = '0;
    logic [12:0] last_freq_sent = '0;

    in_item_t  pending_requests [$];
    out_item_t frame_bytes [$];

    int unsigned requests_taken    = 0;
    int unsigned mismatches        = 0;
    int unsigned quiet_cycles      = 0;
    int unsigned send_idle_pct     = 0;
    int unsigned sink_stall_pct    = 0;
    int unsigned send_gap          = 0;
    int unsigned stall_left        = 0;
    bit          backpressure_done = 1'b0;

    quadcopter_rc_packet_builder_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Stick scaling: truncating division, then saturation to one byte.
    function automatic logic [7:0] stick_code(input logic signed [15:0] raw);
        int v;
        v = int'(raw) * 128 / FULL_SCALE_DEF + 128;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic void build_frame(input in_item_t req);
        logic [7:0]  body [FRAME_BYTES];
        logic [7:0]  sum;
        logic [12:0] freq;
        out_item_t   b;
        for (int i = 0; i < FRAME_BYTES; i++)
            body[i] = 8'h00;
        if (req.mode) begin
            body[0]  = req.bind_code;
            body[1]  = rf_channel;
            body[2]  = session[31:24];
            body[3]  = session[23:16];
            body[4]  = session[15:8];
            body[5]  = session[7:0];
            body[6]  = BIND_B6;
            body[7]  = BIND_B7;
            body[8]  = BIND_B8;
            body[9]  = BIND_B9;
            body[10] = BIND_B10;
        end else begin
            freq = FREQ_BASE + 13'(video_option) * 13'd5;
            if (last_freq_sent != freq || data_frames == STARTUP_FRAMES) begin
                last_freq_sent = freq;
                body[0] = HDR_VIDEO;
                body[1] = 8'(freq >> 8);
                body[2] = freq[7:0];
                body[3] = VIDEO_TRAILER;
                if (data_frames < COUNT_MAX)
                    data_frames++;
            end else begin
                body[0] = HDR_THROTTLE;
                body[2] = stick_code(req.throttle);
            end
            body[4] = 8'hff - stick_code(req.rudder);
            body[6] = 8'hff - stick_code(req.elevator);
            body[8] = stick_code(req.aileron);
            // The counter reached here already includes a video frame sent above.
            if (data_frames < STARTUP_FRAMES) begin
                body[9] = FLAGS_STARTUP;
                data_frames++;
            end else begin
                body[9] = FLAGS_BASE;
                if (!req.aux_led[15])
                    body[9] |= LED_FLAG_BIT;
                if (!req.aux_flip[15])
                    body[9] |= FLIP_FLAG_BIT;
                if (!req.aux_video[15] && req.aux_video != 16'sd0)
                    body[9] |= VIDEO_FLAG_BIT;
            end
            body[10] = DATA_TAIL;
        end
        body[11] = tx_id[31:24];
        body[12] = tx_id[23:16];
        body[13] = tx_id[15:8];
        body[14] = tx_id[7:0];
        sum = 8'h00;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            sum += body[i];
        body[FRAME_BYTES-1] = 8'h00 - sum;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            b.frame_byte    = body[i];
            b.byte_position = POS_W'(i);
            b.last_byte     = (i == FRAME_BYTES - 1);
            frame_bytes.push_back(b);
        end
    endfunction

    function automatic logic [15:0] corner_stick(input int k);
        case (k % 15)
            0:       return 16'sd0;
            1:       return 16'sh7fff;
            2:       return 16'sh8000;
            3:       return 16'sd500;
            4:       return -16'sd500;
            5:       return 16'sd501;
            6:       return -16'sd501;
            7:       return 16'sd499;
            8:       return -16'sd1;
            9:       return -16'sd3;
            10:      return -16'sd4;
            11:      return 16'sd4;
            12:      return 16'sd250;
            13:      return 16'sd1;
            default: return -16'sd250;
        endcase
    endfunction

    function automatic logic [15:0] random_stick();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return corner_stick($urandom_range(0, 14));
            default: return 16'(int'($urandom_range(0, 1200)) - 600);
        endcase
    endfunction

    function automatic in_item_t corner_request(input int k, input logic bind_frame);
        in_item_t req;
        req.mode      = bind_frame;
        req.bind_code = (k == 5) ? 8'h00 : (k == 11) ? 8'hff : 8'h5a;
        req.throttle  = corner_stick(k);
        req.rudder    = corner_stick(k + 1);
        req.elevator  = corner_stick(k + 2);
        req.aileron   = corner_stick(k + 3);
        req.aux_led   = corner_stick(k + 4);
        req.aux_flip  = corner_stick(k + 6);
        req.aux_video = corner_stick(k + 8);
        return req;
    endfunction

    function automatic in_item_t random_request();
        in_item_t req;
        req.mode      = ($urandom_range(0, 99) < 15);
        req.bind_code = 8'($urandom);
        req.throttle  = random_stick();
        req.rudder    = random_stick();
        req.elevator  = random_stick();
        req.aileron   = random_stick();
        req.aux_led   = random_stick();
        req.aux_flip  = random_stick();
        req.aux_video = random_stick();
        return req;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_VIDEO_FREQ_OPTION: video_option = val[6:0];
            REG_TRANSMITTER_ID:    tx_id        = val;
            REG_SESSION_ID:        session      = val;
            REG_RADIO_CHANNEL:     rf_channel   = val[7:0];
            default: ;
        endcase
    endtask

    // Queues the random requests of one phase and waits until every byte has come back.
    task automatic run_phase(input int count, input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            pending_requests.push_back(random_request());
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || frame_bytes.size() != 0);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < 18; k++)
            pending_requests.push_back(corner_request(k, (k % 6) == 5));
        run_phase(0, 0, 0);

        write_reg(REG_VIDEO_FREQ_OPTION, 32'hffff_ffff);
        write_reg(REG_TRANSMITTER_ID, 32'h0000_0000);
        write_reg(REG_SESSION_ID, 32'hffff_ffff);
        write_reg(REG_RADIO_CHANNEL, 32'hffff_ffff);
        write_reg(REG_SPARE, $urandom);
        write_reg(REG_LAST_INDEX, $urandom);
        run_phase(80, 30, 30);

        write_reg(REG_VIDEO_FREQ_OPTION, 32'h0000_0000);
        write_reg(REG_TRANSMITTER_ID, 32'hffff_ffff);
        write_reg(REG_SESSION_ID, 32'h0000_0000);
        write_reg(REG_RADIO_CHANNEL, 32'h0000_0000);
        run_phase(80, 10, 50);

        write_reg(REG_VIDEO_FREQ_OPTION, $urandom);
        write_reg(REG_TRANSMITTER_ID, $urandom);
        write_reg(REG_SESSION_ID, $urandom);
        write_reg(REG_RADIO_CHANNEL, $urandom);
        run_phase(80, 50, 10);

        write_reg(REG_VIDEO_FREQ_OPTION, $urandom);
        run_phase(70, 0, 0);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && frame_bytes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Request driver: holds a request until it is taken, with random idle bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                build_frame(s_data);
                requests_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    s_valid <= 1'b0;
                end else if ($urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(0, 8);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= pending_requests.pop_front();
                end
            end
        end
    end

    // Byte monitor. Once, early in the run, it holds m_ready low long enough
    // for the block to fill up and push back on requests.
    always @(posedge aclk) begin : byte_monitor
        out_item_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_bytes.size() == 0) begin
                    $display("%0t: byte with no frame pending: expected none, actual %p",
                             $time, m_data);
                    mismatches++;
                end else begin
                    due = frame_bytes.pop_front();
                    if (m_data.frame_byte !== due.frame_byte) begin
                        $display("%0t: frame_byte expected %h actual %h (position %0d)",
                                 $time, due.frame_byte, m_data.frame_byte, due.byte_position);
                        mismatches++;
                    end
                    if (m_data.byte_position !== due.byte_position) begin
                        $display("%0t: byte_position expected %0d actual %0d",
                                 $time, due.byte_position, m_data.byte_position);
                        mismatches++;
                    end
                    if (m_data.last_byte !== due.last_byte) begin
                        $display("%0t: last_byte expected %b actual %b (position %0d)",
                                 $time, due.last_byte, m_data.last_byte, due.byte_position);
                        mismatches++;
                    end
                end
            end
            if (!backpressure_done && requests_taken >= BACKPRESSURE_AFTER) begin
                backpressure_done = 1'b1;
                stall_left = BACKPRESSURE_CYCLES;
            end else if (stall_left == 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
